### src/sbt_pkg.sv
package sbt_pkg;

    localparam int POS_BITS = 20;
    localparam int KW_CHARS = 7;
    localparam int KW_COUNT = 29;
    localparam int WORD_BITS = 8 * KW_CHARS;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    // Token kinds.
    localparam logic [5:0] K_EOF    = 6'd0;
    localparam logic [5:0] K_ERROR  = 6'd1;
    localparam logic [5:0] K_IDENT  = 6'd2;
    localparam logic [5:0] K_NUMBER = 6'd3;
    localparam logic [5:0] K_STRING = 6'd4;
    localparam logic [5:0] K_KW0    = 6'd5;
    localparam logic [5:0] K_LPAR   = 6'd34;
    localparam logic [5:0] K_RPAR   = 6'd35;
    localparam logic [5:0] K_LBRACE = 6'd36;
    localparam logic [5:0] K_RBRACE = 6'd37;
    localparam logic [5:0] K_LBRACK = 6'd38;
    localparam logic [5:0] K_RBRACK = 6'd39;
    localparam logic [5:0] K_COMMA  = 6'd40;
    localparam logic [5:0] K_SEMI   = 6'd41;
    localparam logic [5:0] K_DOT    = 6'd42;
    localparam logic [5:0] K_COLON  = 6'd43;
    localparam logic [5:0] K_QUEST  = 6'd44;
    localparam logic [5:0] K_PLUS   = 6'd45;
    localparam logic [5:0] K_MINUS  = 6'd46;
    localparam logic [5:0] K_STAR   = 6'd47;
    localparam logic [5:0] K_SLASH  = 6'd48;
    localparam logic [5:0] K_PCT    = 6'd49;
    localparam logic [5:0] K_LT     = 6'd50;
    localparam logic [5:0] K_LE     = 6'd51;
    localparam logic [5:0] K_GT     = 6'd52;
    localparam logic [5:0] K_GE     = 6'd53;
    localparam logic [5:0] K_EQ     = 6'd54;
    localparam logic [5:0] K_EQEQ   = 6'd55;
    localparam logic [5:0] K_ARROW  = 6'd56;
    localparam logic [5:0] K_NEQ    = 6'd57;

    // Error kinds.
    localparam logic [1:0] E_NONE  = 2'd0;
    localparam logic [1:0] E_UNTERM = 2'd1;
    localparam logic [1:0] E_UNEXP = 2'd2;

    typedef enum logic [3:0] {
        M_START, M_IDENT, M_INT, M_FRAC, M_STR, M_ESC,
        M_HELD, M_LINE, M_BLOCK, M_BSTAR, M_DRAIN
    } mode_t;

    typedef struct packed {
        logic [5:0]          kind;
        logic [POS_BITS-1:0] start;
        logic [POS_BITS-1:0] len;
        logic [POS_BITS-1:0] line;
        logic [1:0]          err;
    } tok_t;

    // All tokens caused by one source byte.
    typedef struct packed {
        logic [1:0]     cnt;
        tok_t [2:0]     tok;
    } step_t;

    localparam logic [WORD_BITS-1:0] KW_TEXT [KW_COUNT] = '{
        WORD_BITS'("server"), WORD_BITS'("route"), WORD_BITS'("tool"),
        WORD_BITS'("func"), WORD_BITS'("return"), WORD_BITS'("if"),
        WORD_BITS'("else"), WORD_BITS'("while"), WORD_BITS'("let"),
        WORD_BITS'("true"), WORD_BITS'("false"), WORD_BITS'("null"),
        WORD_BITS'("and"), WORD_BITS'("or"), WORD_BITS'("not"),
        WORD_BITS'("type"), WORD_BITS'("int"), WORD_BITS'("float"),
        WORD_BITS'("string"), WORD_BITS'("bool"), WORD_BITS'("Result"),
        WORD_BITS'("get"), WORD_BITS'("head"), WORD_BITS'("post"),
        WORD_BITS'("put"), WORD_BITS'("patch"), WORD_BITS'("delete"),
        WORD_BITS'("options"), WORD_BITS'("verbs")
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd6, 4'd5, 4'd4, 4'd4, 4'd6, 4'd2, 4'd4, 4'd5, 4'd3, 4'd4,
        4'd5, 4'd4, 4'd3, 4'd2, 4'd3, 4'd4, 4'd3, 4'd5, 4'd6, 4'd4,
        4'd6, 4'd3, 4'd4, 4'd4, 4'd3, 4'd5, 4'd6, 4'd7, 4'd5
    };

    // Keyword lookup over the collected word; a match gives the keyword kind.
    function automatic logic [5:0] word_kind(input logic [WORD_BITS-1:0] word,
                                             input logic [3:0] cnt);
        logic [5:0] k;
        k = K_IDENT;
        for (int i = 0; i < KW_COUNT; i++) begin
            if (KW_LEN[i] == cnt && KW_TEXT[i] == word) begin
                k = K_KW0 + 6'(i);
            end
        end
        return k;
    endfunction

    function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
        return (v == POS_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic is_numeral(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    endfunction

endpackage

### src/source_byte_tokenizer_top.sv
// Source byte tokenizer.
// Input channel: drive source_byte and raise push; the byte is taken on a
// rising edge with push high and full low. A zero byte ends the source and
// returns all counters to their reset values for the next source.
// Result channel: while empty is low the oldest token sits on token_kind,
// start_position, token_length, line_number, error_kind and last_of_run;
// it is taken on a rising edge with pop high. last_of_run marks the final
// token caused by one byte (a byte causes up to three tokens).
// A token enters the queue on the edge that takes the byte completing it.
// It takes one byte per cycle while full is low and gives one token per cycle
// while pop is high and empty is low; each byte is decided combinationally.
// A four-entry queue of per-byte token groups sits between scanner and
// output; when the receiver stalls it fills and full holds off further bytes.
// Reset (rst_n low) empties the queue and puts the scanner at line one,
// offset zero, at the start of a token.
module source_byte_tokenizer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  source_byte,
    output logic        empty,
    input  logic        pop,
    output logic [5:0]  token_kind,
    output logic [19:0] start_position,
    output logic [19:0] token_length,
    output logic [19:0] line_number,
    output logic [1:0]  error_kind,
    output logic        last_of_run
);

    logic              accept;
    logic              step_valid;
    sbt_pkg::step_t    step;
    sbt_pkg::tok_t     tok;

    // A pushed byte enters whenever the queue has room.
    assign accept = push && !full;

    sbt_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .source_byte (source_byte),
        .step_valid  (step_valid),
        .step        (step)
    );

    sbt_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept && step_valid),
        .wr_step (step),
        .full    (full),
        .empty   (empty),
        .pop     (pop),
        .tok     (tok),
        .last    (last_of_run)
    );

    // Result fields.
    assign token_kind     = tok.kind;
    assign start_position = tok.start;
    assign token_length   = tok.len;
    assign line_number    = tok.line;
    assign error_kind     = tok.err;

endmodule

### src/sbt_front.sv
module sbt_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        source_byte,
    output logic              step_valid,
    output sbt_pkg::step_t    step
);

    sbt_pkg::mode_t                    mode_reg, mode_next;
    logic [sbt_pkg::POS_BITS-1:0]      pos_reg, pos_next;
    logic [sbt_pkg::POS_BITS-1:0]      line_reg, line_next;
    logic [sbt_pkg::POS_BITS-1:0]      begin_reg, begin_next;
    logic [sbt_pkg::WORD_BITS-1:0]     word_reg, word_next;
    logic [3:0]                        wcnt_reg, wcnt_next;
    logic [7:0]                        held_reg, held_next;

    // One scan step: extend or close the pending token; the byte may start a token.
    always_comb
    begin
        logic       do_start;
        logic [1:0] n;
        logic [7:0] c;
        logic [5:0] k1;
        logic [5:0] k2;
        sbt_pkg::tok_t t;
        c = source_byte;
        do_start = 1'b0;
        n = 2'd0;
        k1 = sbt_pkg::K_EOF;
        k2 = sbt_pkg::K_EOF;
        step = '0;
        mode_next = mode_reg;
        pos_next = pos_reg;
        line_next = line_reg;
        begin_next = begin_reg;
        word_next = word_reg;
        wcnt_next = wcnt_reg;
        held_next = held_reg;
        t = '0;
        t.line = line_reg;

        unique case (mode_reg)
            sbt_pkg::M_START:
            begin
                do_start = 1'b1;
            end
            sbt_pkg::M_IDENT:
            begin
                if (sbt_pkg::is_alpha(c) || sbt_pkg::is_numeral(c)) begin
                    if (wcnt_reg < 4'(sbt_pkg::KW_CHARS)) begin
                        word_next = {word_reg[sbt_pkg::WORD_BITS-9:0], c};
                        wcnt_next = wcnt_reg + 4'd1;
                    end else begin
                        wcnt_next = 4'(sbt_pkg::KW_CHARS + 1);
                    end
                end else begin
                    t.kind = sbt_pkg::word_kind(word_reg, wcnt_reg);
                    t.start = begin_reg;
                    t.len = pos_reg - begin_reg;
                    step.tok[n] = t;
                    n = n + 2'd1;
                    do_start = 1'b1;
                end
            end
            sbt_pkg::M_INT, sbt_pkg::M_FRAC:
            begin
                if (sbt_pkg::is_numeral(c)) begin
                    mode_next = mode_reg;
                end else if (c == "." && mode_reg == sbt_pkg::M_INT) begin
                    mode_next = sbt_pkg::M_FRAC;
                end else begin
                    t.kind = sbt_pkg::K_NUMBER;
                    t.start = begin_reg;
                    t.len = pos_reg - begin_reg;
                    step.tok[n] = t;
                    n = n + 2'd1;
                    do_start = 1'b1;
                end
            end
            sbt_pkg::M_STR:
            begin
                if (c == "\"") begin
                    t.kind = sbt_pkg::K_STRING;
                    t.start = begin_reg;
                    t.len = sbt_pkg::sat_inc(pos_reg - begin_reg);
                    step.tok[n] = t;
                    n = n + 2'd1;
                    mode_next = sbt_pkg::M_START;
                end else if (c == "\\") begin
                    mode_next = sbt_pkg::M_ESC;
                end else if (c == "\n" || c == 8'd0) begin
                    t.kind = sbt_pkg::K_ERROR;
                    t.start = begin_reg;
                    t.err = sbt_pkg::E_UNTERM;
                    step.tok[0] = t;
                    t.kind = sbt_pkg::K_EOF;
                    t.err = sbt_pkg::E_NONE;
                    step.tok[1] = t;
                    n = 2'd2;
                    mode_next = sbt_pkg::M_DRAIN;
                end
            end
            sbt_pkg::M_ESC:
            begin
                if (c == 8'd0) begin
                    t.kind = sbt_pkg::K_ERROR;
                    t.start = begin_reg;
                    t.err = sbt_pkg::E_UNTERM;
                    step.tok[0] = t;
                    t.kind = sbt_pkg::K_EOF;
                    t.err = sbt_pkg::E_NONE;
                    step.tok[1] = t;
                    n = 2'd2;
                    mode_next = sbt_pkg::M_DRAIN;
                end else begin
                    mode_next = sbt_pkg::M_STR;
                end
            end
            sbt_pkg::M_HELD:
            begin
                t.start = begin_reg;
                priority case (held_reg)
                    "<":
                    begin
                        k1 = sbt_pkg::K_LT;
                        if (c == "=") k2 = sbt_pkg::K_LE;
                    end
                    ">":
                    begin
                        k1 = sbt_pkg::K_GT;
                        if (c == "=") k2 = sbt_pkg::K_GE;
                    end
                    "=":
                    begin
                        k1 = sbt_pkg::K_EQ;
                        if (c == "=") k2 = sbt_pkg::K_EQEQ;
                        else if (c == ">") k2 = sbt_pkg::K_ARROW;
                    end
                    "!":
                    begin
                        if (c == "=") k2 = sbt_pkg::K_NEQ;
                        else k1 = sbt_pkg::K_ERROR;
                    end
                    "/":
                    begin
                        k1 = sbt_pkg::K_SLASH;
                    end
                    default:
                    begin
                        k1 = sbt_pkg::K_EOF;
                    end
                endcase
                if (held_reg == "/" && c == "/") begin
                    mode_next = sbt_pkg::M_LINE;
                end else if (held_reg == "/" && c == "*") begin
                    mode_next = sbt_pkg::M_BLOCK;
                end else if (k2 != sbt_pkg::K_EOF) begin
                    t.kind = k2;
                    t.len = sbt_pkg::POS_BITS'(2);
                    step.tok[0] = t;
                    n = 2'd1;
                    mode_next = sbt_pkg::M_START;
                end else if (k1 == sbt_pkg::K_ERROR) begin
                    t.kind = sbt_pkg::K_ERROR;
                    t.err = sbt_pkg::E_UNEXP;
                    step.tok[0] = t;
                    t.kind = sbt_pkg::K_EOF;
                    t.err = sbt_pkg::E_NONE;
                    step.tok[1] = t;
                    n = 2'd2;
                    mode_next = sbt_pkg::M_DRAIN;
                end else if (k1 != sbt_pkg::K_EOF) begin
                    t.kind = k1;
                    t.len = sbt_pkg::POS_BITS'(1);
                    step.tok[0] = t;
                    n = 2'd1;
                    do_start = 1'b1;
                end else begin
                    do_start = 1'b1;
                end
            end
            sbt_pkg::M_LINE:
            begin
                if (c == "\n" || c == 8'd0) do_start = 1'b1;
            end
            sbt_pkg::M_BLOCK, sbt_pkg::M_BSTAR:
            begin
                if (c == 8'd0) begin
                    do_start = 1'b1;
                end else if (c == "\n") begin
                    line_next = sbt_pkg::sat_inc(line_reg);
                    mode_next = sbt_pkg::M_BLOCK;
                end else if (c == "*") begin
                    mode_next = sbt_pkg::M_BSTAR;
                end else if (c == "/" && mode_reg == sbt_pkg::M_BSTAR) begin
                    mode_next = sbt_pkg::M_START;
                end else begin
                    mode_next = sbt_pkg::M_BLOCK;
                end
            end
            sbt_pkg::M_DRAIN:
            begin
                mode_next = sbt_pkg::M_DRAIN;
            end
            default:
            begin
                do_start = 1'b1;
            end
        endcase

        // Token start handling for the current byte.
        if (do_start) begin
            t = '0;
            t.line = line_reg;
            t.start = pos_reg;
            mode_next = sbt_pkg::M_START;
            if (c == 8'd0) begin
                t.kind = sbt_pkg::K_EOF;
                step.tok[n] = t;
                n = n + 2'd1;
            end else if (c == " " || c == "\t" || c == 8'h0d) begin
                mode_next = sbt_pkg::M_START;
            end else if (c == "\n") begin
                line_next = sbt_pkg::sat_inc(line_reg);
            end else begin
                begin_next = pos_reg;
                if (sbt_pkg::is_numeral(c)) begin
                    mode_next = sbt_pkg::M_INT;
                end else if (sbt_pkg::is_alpha(c)) begin
                    word_next = sbt_pkg::WORD_BITS'(c);
                    wcnt_next = 4'd1;
                    mode_next = sbt_pkg::M_IDENT;
                end else if (c == "\"") begin
                    mode_next = sbt_pkg::M_STR;
                end else if (c == "<" || c == ">" || c == "=" || c == "!" || c == "/") begin
                    held_next = c;
                    mode_next = sbt_pkg::M_HELD;
                end else begin
                    t.len = sbt_pkg::POS_BITS'(1);
                    unique case (c)
                        "(": t.kind = sbt_pkg::K_LPAR;
                        ")": t.kind = sbt_pkg::K_RPAR;
                        "{": t.kind = sbt_pkg::K_LBRACE;
                        "}": t.kind = sbt_pkg::K_RBRACE;
                        "[": t.kind = sbt_pkg::K_LBRACK;
                        "]": t.kind = sbt_pkg::K_RBRACK;
                        ",": t.kind = sbt_pkg::K_COMMA;
                        ";": t.kind = sbt_pkg::K_SEMI;
                        ".": t.kind = sbt_pkg::K_DOT;
                        ":": t.kind = sbt_pkg::K_COLON;
                        "?": t.kind = sbt_pkg::K_QUEST;
                        "+": t.kind = sbt_pkg::K_PLUS;
                        "-": t.kind = sbt_pkg::K_MINUS;
                        "*": t.kind = sbt_pkg::K_STAR;
                        "%": t.kind = sbt_pkg::K_PCT;
                        default: t.kind = sbt_pkg::K_ERROR;
                    endcase
                    if (t.kind == sbt_pkg::K_ERROR) begin
                        t.len = '0;
                        t.err = sbt_pkg::E_UNEXP;
                        step.tok[n] = t;
                        n = n + 2'd1;
                        t.kind = sbt_pkg::K_EOF;
                        t.err = sbt_pkg::E_NONE;
                        mode_next = sbt_pkg::M_DRAIN;
                    end
                    step.tok[n] = t;
                    n = n + 2'd1;
                end
            end
        end

        // The zero byte ends the source and returns everything to reset values.
        if (c == 8'd0) begin
            mode_next = sbt_pkg::M_START;
            pos_next = '0;
            line_next = sbt_pkg::POS_BITS'(1);
            begin_next = '0;
            word_next = '0;
            wcnt_next = '0;
            held_next = '0;
        end else begin
            pos_next = sbt_pkg::sat_inc(pos_reg);
        end
        step.cnt = n;
        step_valid = (n != 2'd0);
    end

    // Scanner state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= sbt_pkg::M_START;
            pos_reg   <= '0;
            line_reg  <= sbt_pkg::POS_BITS'(1);
            begin_reg <= '0;
            word_reg  <= '0;
            wcnt_reg  <= '0;
            held_reg  <= '0;
        end else if (accept) begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            line_reg  <= line_next;
            begin_reg <= begin_next;
            word_reg  <= word_next;
            wcnt_reg  <= wcnt_next;
            held_reg  <= held_next;
        end
    end

endmodule

### src/sbt_back.sv
module sbt_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  sbt_pkg::step_t    wr_step,
    output logic              full,
    output logic              empty,
    input  logic              pop,
    output sbt_pkg::tok_t     tok,
    output logic              last
);

    sbt_pkg::step_t                    mem_reg [sbt_pkg::QUEUE_DEPTH];
    logic [sbt_pkg::QPTR_BITS-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [sbt_pkg::QPTR_BITS:0]       count_reg, count_next;
    logic [1:0]                        slot_reg;
    sbt_pkg::step_t                    head;
    logic                              pop_fire;
    logic                              done;

    // Head step record and the token currently offered.
    always_comb
    begin
        head = mem_reg[rd_ptr_reg];
        empty = (count_reg == '0);
        full = (count_reg == (sbt_pkg::QPTR_BITS+1)'(sbt_pkg::QUEUE_DEPTH));
        tok = head.tok[slot_reg];
        last = (slot_reg == head.cnt - 2'd1);
        pop_fire = pop && !empty;
        done = pop_fire && last;
        count_next = count_reg + (sbt_pkg::QPTR_BITS+1)'(wr_en)
                   - (sbt_pkg::QPTR_BITS+1)'(done);
    end

    // Step record storage.
    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_step;
        end
    end

    // Queue pointers and the token index within the head record.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            slot_reg   <= '0;
        end else begin
            count_reg <= count_next;
            if (wr_en) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (done) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
                slot_reg   <= '0;
            end else if (pop_fire) begin
                slot_reg <= slot_reg + 2'd1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !wr_en)
        else $error("step written into a full queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (sbt_pkg::QPTR_BITS+1)'(sbt_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (head.cnt != 2'd0 && slot_reg < head.cnt))
        else $error("token index beyond the head record");

    a_slot_reset: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> slot_reg == 2'd0)
        else $error("token index not cleared after the last token");

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

    // One expected or observed token.
    typedef struct {
        logic [5:0]  kind;
        logic [19:0] start;
        logic [19:0] len;
        logic [19:0] line;
        logic [1:0]  err;
        logic        last;
    } token_rec_t;

    // Scoreboard: a lexer model that turns accepted bytes into expected tokens.
    class token_scoreboard;
        sbt_pkg::mode_t mode;
        logic [19:0] pos;
        logic [19:0] line;
        logic [19:0] begin_pos;
        logic [55:0] word;
        logic [3:0]  word_len;
        logic [7:0]  held;
        token_rec_t  pending[$];
        token_rec_t  batch[$];
        int          failures;

        function void clear_state();
            mode = sbt_pkg::M_START;
            pos = '0;
            line = 20'd1;
            begin_pos = '0;
            word = '0;
            word_len = '0;
            held = '0;
        endfunction

        function logic [19:0] sat_up(logic [19:0] v, logic [19:0] d);
            logic [20:0] s;
            s = {1'b0, v} + {1'b0, d};
            return s[20] ? 20'hFFFFF : s[19:0];
        endfunction

        function void emit(logic [5:0] k, logic [19:0] s, logic [19:0] l, logic [1:0] e);
            token_rec_t t;
            t.kind = k;
            t.start = s;
            t.len = l;
            t.line = line;
            t.err = e;
            t.last = 1'b0;
            batch.push_back(t);
        endfunction

        function void fail_with(logic [19:0] s, logic [1:0] e);
            emit(sbt_pkg::K_ERROR, s, '0, e);
            emit(sbt_pkg::K_EOF, s, '0, sbt_pkg::E_NONE);
            mode = sbt_pkg::M_DRAIN;
        endfunction

        function void grow_word(logic [7:0] c);
            if (word_len < 4'd7) begin
                word = {word[47:0], c};
                word_len++;
            end else begin
                word_len = 4'd8;
            end
        endfunction

        function logic [5:0] classify_word();
            logic [5:0] k;
            k = sbt_pkg::K_IDENT;
            if (word_len <= 4'd7) begin
                for (int i = 0; i < sbt_pkg::KW_COUNT; i++) begin
                    if (sbt_pkg::KW_LEN[i] == word_len && sbt_pkg::KW_TEXT[i] == word)
                        k = sbt_pkg::K_KW0 + 6'(i);
                end
            end
            return k;
        endfunction

        function bit digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit letter(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
        endfunction

        // Handling of a byte at the start of a token.
        function void fresh_byte(logic [7:0] c);
            logic [5:0] single_kind;
            mode = sbt_pkg::M_START;
            single_kind = sbt_pkg::K_EOF;
            case (c)
                "(": single_kind = sbt_pkg::K_LPAR;
                ")": single_kind = sbt_pkg::K_RPAR;
                "{": single_kind = sbt_pkg::K_LBRACE;
                "}": single_kind = sbt_pkg::K_RBRACE;
                "[": single_kind = sbt_pkg::K_LBRACK;
                "]": single_kind = sbt_pkg::K_RBRACK;
                ",": single_kind = sbt_pkg::K_COMMA;
                ";": single_kind = sbt_pkg::K_SEMI;
                ".": single_kind = sbt_pkg::K_DOT;
                ":": single_kind = sbt_pkg::K_COLON;
                "?": single_kind = sbt_pkg::K_QUEST;
                "+": single_kind = sbt_pkg::K_PLUS;
                "-": single_kind = sbt_pkg::K_MINUS;
                "*": single_kind = sbt_pkg::K_STAR;
                "%": single_kind = sbt_pkg::K_PCT;
                default: single_kind = sbt_pkg::K_EOF;
            endcase
            if (c == 8'd0) begin
                emit(sbt_pkg::K_EOF, pos, '0, sbt_pkg::E_NONE);
                return;
            end
            if (c == " " || c == 8'h09 || c == 8'h0d)
                return;
            if (c == 8'h0a) begin
                line = sat_up(line, 20'd1);
                return;
            end
            begin_pos = pos;
            if (digit(c)) begin
                mode = sbt_pkg::M_INT;
            end else if (letter(c)) begin
                word = '0;
                word_len = '0;
                grow_word(c);
                mode = sbt_pkg::M_IDENT;
            end else if (c == "\"") begin
                mode = sbt_pkg::M_STR;
            end else if (c == "<" || c == ">" || c == "=" || c == "!" || c == "/") begin
                held = c;
                mode = sbt_pkg::M_HELD;
            end else if (single_kind != sbt_pkg::K_EOF) begin
                emit(single_kind, pos, 20'd1, sbt_pkg::E_NONE);
            end else begin
                fail_with(pos, sbt_pkg::E_UNEXP);
            end
        endfunction

        // Second byte after a possible two-character operator.
        function void after_held(logic [7:0] c);
            logic [5:0] first;
            logic [5:0] pair;
            pair = sbt_pkg::K_EOF;
            case (held)
                "<": begin first = sbt_pkg::K_LT; if (c == "=") pair = sbt_pkg::K_LE; end
                ">": begin first = sbt_pkg::K_GT; if (c == "=") pair = sbt_pkg::K_GE; end
                "=": begin
                    first = sbt_pkg::K_EQ;
                    if (c == "=") pair = sbt_pkg::K_EQEQ;
                    else if (c == ">") pair = sbt_pkg::K_ARROW;
                end
                "!": begin
                    if (c == "=") begin
                        emit(sbt_pkg::K_NEQ, begin_pos, 20'd2, sbt_pkg::E_NONE);
                        mode = sbt_pkg::M_START;
                    end else begin
                        fail_with(begin_pos, sbt_pkg::E_UNEXP);
                    end
                    return;
                end
                default: begin
                    if (c == "/") begin mode = sbt_pkg::M_LINE; return; end
                    if (c == "*") begin mode = sbt_pkg::M_BLOCK; return; end
                    first = sbt_pkg::K_SLASH;
                end
            endcase
            if (pair != sbt_pkg::K_EOF) begin
                emit(pair, begin_pos, 20'd2, sbt_pkg::E_NONE);
                mode = sbt_pkg::M_START;
                return;
            end
            emit(first, begin_pos, 20'd1, sbt_pkg::E_NONE);
            fresh_byte(c);
        endfunction

        // Notes an accepted byte and queues the tokens it causes.
        function void note_byte(logic [7:0] c);
            batch.delete();
            case (mode)
                sbt_pkg::M_START: fresh_byte(c);
                sbt_pkg::M_IDENT: begin
                    if (letter(c) || digit(c)) begin
                        grow_word(c);
                    end else begin
                        emit(classify_word(), begin_pos, pos - begin_pos, sbt_pkg::E_NONE);
                        fresh_byte(c);
                    end
                end
                sbt_pkg::M_INT, sbt_pkg::M_FRAC: begin
                    if (digit(c)) begin
                    end else if (c == "." && mode == sbt_pkg::M_INT) begin
                        mode = sbt_pkg::M_FRAC;
                    end else begin
                        emit(sbt_pkg::K_NUMBER, begin_pos, pos - begin_pos, sbt_pkg::E_NONE);
                        fresh_byte(c);
                    end
                end
                sbt_pkg::M_STR: begin
                    if (c == "\"") begin
                        emit(sbt_pkg::K_STRING, begin_pos, sat_up(pos - begin_pos, 20'd1),
                             sbt_pkg::E_NONE);
                        mode = sbt_pkg::M_START;
                    end else if (c == "\\") begin
                        mode = sbt_pkg::M_ESC;
                    end else if (c == 8'h0a || c == 8'd0) begin
                        fail_with(begin_pos, sbt_pkg::E_UNTERM);
                    end
                end
                sbt_pkg::M_ESC: begin
                    if (c == 8'd0) fail_with(begin_pos, sbt_pkg::E_UNTERM);
                    else mode = sbt_pkg::M_STR;
                end
                sbt_pkg::M_HELD: after_held(c);
                sbt_pkg::M_LINE: begin
                    if (c == 8'h0a || c == 8'd0) fresh_byte(c);
                end
                sbt_pkg::M_BLOCK, sbt_pkg::M_BSTAR: begin
                    if (c == 8'd0) begin
                        fresh_byte(c);
                    end else if (c == 8'h0a) begin
                        line = sat_up(line, 20'd1);
                        mode = sbt_pkg::M_BLOCK;
                    end else if (c == "*") begin
                        mode = sbt_pkg::M_BSTAR;
                    end else if (c == "/" && mode == sbt_pkg::M_BSTAR) begin
                        mode = sbt_pkg::M_START;
                    end else begin
                        mode = sbt_pkg::M_BLOCK;
                    end
                end
                sbt_pkg::M_DRAIN: begin
                end
                default: fresh_byte(c);
            endcase
            if (batch.size() > 0)
                batch[batch.size() - 1].last = 1'b1;
            foreach (batch[i])
                pending.push_back(batch[i]);
            if (c == 8'd0) clear_state();
            else pos = sat_up(pos, 20'd1);
        endfunction

        // Compares an accepted token with the oldest expectation.
        function void check_token(token_rec_t got);
            token_rec_t want;
            if (pending.size() == 0) begin
                $display("%0t: token with none expected: kind %0d", $time, got.kind);
                failures++;
                return;
            end
            want = pending.pop_front();
            if (got.kind !== want.kind) begin
                $display("%0t: token_kind expected %0d actual %0d", $time, want.kind, got.kind);
                failures++;
            end
            if (got.start !== want.start) begin
                $display("%0t: start_position expected %0d actual %0d",
                         $time, want.start, got.start);
                failures++;
            end
            if (got.len !== want.len) begin
                $display("%0t: token_length expected %0d actual %0d", $time, want.len, got.len);
                failures++;
            end
            if (got.line !== want.line) begin
                $display("%0t: line_number expected %0d actual %0d", $time, want.line, got.line);
                failures++;
            end
            if (got.err !== want.err) begin
                $display("%0t: error_kind expected %0d actual %0d", $time, want.err, got.err);
                failures++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last_of_run expected %0d actual %0d",
                         $time, want.last, got.last);
                failures++;
            end
        endfunction
    endclass

    localparam int STALL_LIMIT = 2000;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  source_byte;
    logic        empty;
    logic        pop;
    logic [5:0]  token_kind;
    logic [19:0] start_position;
    logic [19:0] token_length;
    logic [19:0] line_number;
    logic [1:0]  error_kind;
    logic        last_of_run;

    token_scoreboard lexer_sb;
    int              idle_cycles;
    int              pop_phase;

    source_byte_tokenizer_top u_top (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .source_byte(source_byte), .empty(empty), .pop(pop),
        .token_kind(token_kind), .start_position(start_position),
        .token_length(token_length), .line_number(line_number),
        .error_kind(error_kind), .last_of_run(last_of_run)
    );

    // Clock generation.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Receiver: stalls on a rotating pattern, with long runs of steady pops.
    always @(posedge clk)
    begin
        if (rst_n) begin
            pop_phase <= pop_phase + 1;
            if (pop_phase % 256 < 96) pop <= 1'b1;
            else pop <= ((pop_phase * 7) % 11) < 5;
        end
    end

    // Result monitor and watchdog.
    always @(posedge clk)
    begin
        token_rec_t got;
        if (rst_n) begin
            if (pop && !empty) begin
                got.kind = token_kind;
                got.start = start_position;
                got.len = token_length;
                got.line = line_number;
                got.err = error_kind;
                got.last = last_of_run;
                lexer_sb.check_token(got);
            end
            if ((pop && !empty) || (push && !full)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles > STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    int burst_left;

    // Sends one byte, with bursty gaps, and waits until it is accepted.
    task automatic send_byte(input logic [7:0] c);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 5);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        push <= 1'b1;
        source_byte <= c;
        @(posedge clk);
        while (full) @(posedge clk);
        lexer_sb.note_byte(c);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // A random fragment of mostly well-formed source text.
    task automatic send_fragment();
        string words[8] = '{"server", "options", "Result", "verbs", "x_1", "optionsx",
                            "delete", "string"};
        string ops[12] = '{"<=", ">=", "==", "=>", "!=", "<", ">", "=", "/", "(", "%", "?"};
        case ($urandom_range(0, 9))
            0: send_text(words[$urandom_range(0, 7)]);
            1: begin
                repeat ($urandom_range(1, 4)) send_byte("0" + 8'($urandom_range(0, 9)));
                if ($urandom_range(0, 1)) send_text(".5");
            end
            2: send_text(ops[$urandom_range(0, 11)]);
            3: send_text("\"a\\\"b\\\n\"");
            4: send_text("// note\n");
            5: send_text("/* a *\n* / **/");
            6: begin
                send_text(" \t");
                send_byte(8'h0d);
                send_byte(8'h0a);
            end
            7: send_byte(8'($urandom_range(0, 255)));
            8: send_text("!x");
            default: send_byte(8'($urandom_range(1, 255)));
        endcase
        if ($urandom_range(0, 2) == 0) send_byte(" ");
    endtask

    // Stimulus.
    initial
    begin
        lexer_sb = new();
        lexer_sb.clear_state();
        lexer_sb.failures = 0;
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        source_byte = 8'd0;
        idle_cycles = 0;
        pop_phase = 0;
        burst_left = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cases: keywords, operators, strings, comments and errors.
        send_text("if Result options optionsx a9 12.34.5;");
        send_byte(8'd0);
        send_text("(){}[],;.:?+-*/%< <= > >= = == => != /");
        send_byte(8'd0);
        send_text("\"ab\\\ncd\" /* x */* / ** / */ // c\n\"open\n");
        send_byte(8'd0);
        send_text("a!b");
        send_byte(8'd0);
        send_text("@ 9");
        send_byte(8'd0);
        send_text("\"esc\\");
        send_byte(8'd0);
        send_text("/* left open");
        send_byte(8'd0);
        send_byte(8'hff);
        send_byte(8'd0);

        // Random sources, mostly well-formed fragments.
        for (int n = 0; n < 25; n++) begin
            send_fragment();
            if ($urandom_range(0, 9) == 0) send_byte(8'd0);
        end
        send_byte(8'd0);
        push <= 1'b0;

        // Drain remaining expected tokens, then let the pipeline settle.
        while (lexer_sb.pending.size() > 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (lexer_sb.failures == 0 && lexer_sb.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

### source_byte_tokenizer_top.f
src/sbt_pkg.sv
src/sbt_front.sv
src/sbt_back.sv
src/source_byte_tokenizer_top.sv
sim/testbench.sv
